// ----- rtl/mpeg1_to_mpeg2_pes_header_top_defines.svh -----
// Assertion macros shared by the PES header rewriter RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef MPEG1_TO_MPEG2_PES_HEADER_TOP_DEFINES_SVH
`define MPEG1_TO_MPEG2_PES_HEADER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define M2PES_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define M2PES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/m2pes_pkg.sv -----
// Types and constants for the MPEG-1 to MPEG-2 PES header rewriter.
// No dependencies; used by m2pes_parse and the top level.
package m2pes_pkg;

  // One input item: a packet byte and its end marker.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_end;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_end;
    logic       packet_bad;
  } out_item_t;

  // What the parser produced for the item it just took.
  typedef struct packed {
    logic      payload;  // item carries one pass-through byte
    logic      header;   // rewritten header is ready to be sent as a burst
    out_item_t item;
  } parse_evt_t;

  // Parse phases, one-hot.
  typedef enum logic [6:0] {
    PH_SYNC    = 7'b0000001,
    PH_REJECT  = 7'b0000010,
    PH_STUFF   = 7'b0000100,
    PH_STD     = 7'b0001000,
    PH_MARK    = 7'b0010000,
    PH_STAMP   = 7'b0100000,
    PH_PAYLOAD = 7'b1000000
  } phase_t;

  // Time stamps present in the packet.
  typedef enum logic [1:0] {
    STAMP_NONE    = 2'd0,
    STAMP_PTS     = 2'd1,
    STAMP_PTS_DTS = 2'd2
  } stamp_kind_t;

  localparam logic [16:0] COUNT_MAX      = 17'h1FFFF;
  localparam logic [7:0]  START_CODE_END = 8'h01;
  localparam logic [7:0]  PRIV_STREAM_1  = 8'hBD;
  localparam logic [7:0]  MPEG2_MARK     = 8'h80;
  localparam logic [7:0]  FLAGS_PTS      = 8'h80;
  localparam logic [7:0]  FLAGS_PTS_DTS  = 8'hC0;
  localparam logic [7:0]  FLAGS_NONE     = 8'h00;
  localparam logic [7:0]  MASK_STAMP_TOP = 8'h0E;
  localparam logic [7:0]  MASK_STAMP_MRK = 8'hFE;
  localparam logic [7:0]  MASK_STAMP_ALL = 8'hFF;
  localparam logic [4:0]  LEN_PTS        = 5'd5;
  localparam logic [4:0]  LEN_PTS_DTS    = 5'd10;
  localparam logic [4:0]  HDR_FIXED_LEN  = 5'd9;
  localparam logic [4:0]  PAYLOAD_MIN    = 5'd4;

  // Stamp byte count for a stamp kind.
  function automatic logic [4:0] stamp_len(stamp_kind_t kind);
    logic [4:0] len;
    unique case (kind)
      STAMP_PTS:     len = LEN_PTS;
      STAMP_PTS_DTS: len = LEN_PTS_DTS;
      default:       len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/m2pes_parse.sv -----
// Header parser: walks the MPEG-1 PES header one item at a time, keeps the
// start code, length and stamp bytes, and serves the rewritten header bytes.
// Depends on m2pes_pkg.
module m2pes_parse import m2pes_pkg::*; #(
  parameter int MAX_STUFFING = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  in_item_t   in_item,
  input  logic [4:0] burst_idx,
  output parse_evt_t evt,
  output logic [7:0] burst_byte,
  output logic [4:0] burst_last
);

  localparam logic [4:0] MAX_STUFF = 5'(MAX_STUFFING);

  // Burst byte positions after the four start-code bytes.
  localparam logic [4:0] BI_LEN_HI = 5'd4;
  localparam logic [4:0] BI_LEN_LO = 5'd5;
  localparam logic [4:0] BI_MARK   = 5'd6;
  localparam logic [4:0] BI_FLAGS  = 5'd7;
  localparam logic [4:0] BI_HLEN   = 5'd8;
  localparam logic [4:0] BI_STAMP0 = 5'd9;

  phase_t      phase_r, phase_nxt;
  logic [16:0] count_r, count_nxt, count_inc;
  logic [4:0]  stuff_r, stuff_nxt;
  stamp_kind_t kind_r, kind_nxt;
  logic        err_r, err_nxt;
  logic [7:0]  hdr_r [6];
  logic [7:0]  stamp_r [10];
  logic [15:0] nl_r, nl_nxt;

  logic        hdr_we, stamp_we, do_marker, trigger, ok;
  logic [3:0]  stamp_widx;
  logic [7:0]  stamp_wdata;
  logic [7:0]  b, mask;
  logic        last;
  logic [3:0]  sidx;
  logic [2:0]  srem;
  logic [4:0]  sidx_inc, total, stuff_dec;
  logic [15:0] decl;

  assign b    = in_item.data_byte;
  assign last = in_item.packet_end;
  assign decl = {hdr_r[4], hdr_r[5]};
  assign count_inc = (count_r < COUNT_MAX) ? count_r + 17'd1 : count_r;

  // Stamp byte mask: first byte of each stamp keeps bits 3..1, marker bytes
  // lose bit 0, the rest pass.
  assign sidx = stuff_r[3:0];
  assign srem = (sidx >= 4'd5) ? 3'(sidx - 4'd5) : sidx[2:0];
  assign mask = (srem == 3'd0) ? MASK_STAMP_TOP :
                (srem == 3'd2 || srem == 3'd4) ? MASK_STAMP_MRK : MASK_STAMP_ALL;
  assign sidx_inc  = stuff_r + 5'd1;
  assign total     = (kind_r == STAMP_PTS_DTS) ? LEN_PTS_DTS : LEN_PTS;
  assign stuff_dec = (stuff_r != 5'd0) ? stuff_r - 5'd1 : 5'd0;

  // Next-state logic for one accepted item.
  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_inc;
    stuff_nxt   = stuff_r;
    kind_nxt    = kind_r;
    err_nxt     = err_r;
    hdr_we      = 1'b0;
    stamp_we    = 1'b0;
    stamp_widx  = sidx;
    stamp_wdata = b & mask;
    do_marker   = 1'b0;
    trigger     = 1'b0;
    ok          = 1'b1;
    evt         = '0;

    unique case (phase_r)
      PH_SYNC: begin
        if (count_r == 17'd0 || count_r == 17'd1) begin
          ok = (b == 8'h00);
        end else if (count_r == 17'd2) begin
          ok = (b == START_CODE_END);
        end else if (count_r == 17'd3) begin
          ok = (b[7:4] == 4'hE) || (b[7:5] == 3'b110) || (b == PRIV_STREAM_1);
        end
        hdr_we = (count_r < 17'd6);
        if (!ok) begin
          phase_nxt = PH_REJECT;
        end else if (count_r >= 17'd5) begin
          phase_nxt = PH_STUFF;
        end
      end
      PH_REJECT: begin
        phase_nxt = PH_REJECT;
      end
      PH_STUFF: begin
        priority if (count_r == 17'd6 && b[7:6] == 2'b10) begin
          phase_nxt = PH_REJECT;
        end else if (b[7]) begin
          if (stuff_r >= MAX_STUFF) begin
            err_nxt = 1'b1;
          end else begin
            stuff_nxt = stuff_r + 5'd1;
          end
        end else if (b[7:6] == 2'b01) begin
          phase_nxt = PH_STD;
        end else begin
          do_marker = 1'b1;
        end
      end
      PH_STD: begin
        phase_nxt = PH_MARK;
      end
      PH_MARK: begin
        do_marker = 1'b1;
      end
      PH_STAMP: begin
        stamp_we  = (stuff_r < 5'd10);
        stuff_nxt = sidx_inc;
        if (sidx_inc >= total) begin
          stuff_nxt = 5'd0;
          phase_nxt = PH_PAYLOAD;
          trigger   = !last;
        end
      end
      PH_PAYLOAD: begin
        stuff_nxt              = stuff_dec;
        evt.payload            = 1'b1;
        evt.item.out_byte      = b;
        evt.item.out_end       = last;
        evt.item.packet_bad    = last && (err_r || stuff_dec != 5'd0 ||
                                 count_inc != ({1'b0, decl} + 17'd6));
      end
      default: begin
        phase_nxt = PH_REJECT;
      end
    endcase

    // Marker byte: either the first stamp byte or the no-stamp code.
    if (do_marker) begin
      if (b[7:5] == 3'b001) begin
        kind_nxt    = b[4] ? STAMP_PTS_DTS : STAMP_PTS;
        stamp_we    = 1'b1;
        stamp_widx  = 4'd0;
        stamp_wdata = b & MASK_STAMP_TOP;
        stuff_nxt   = 5'd1;
        phase_nxt   = PH_STAMP;
      end else begin
        kind_nxt  = STAMP_NONE;
        stuff_nxt = PAYLOAD_MIN;
        phase_nxt = PH_PAYLOAD;
        trigger   = !last;
      end
    end

    evt.header = trigger;

    // The last byte of any packet returns to start-code search.
    if (last) begin
      phase_nxt = PH_SYNC;
      count_nxt = 17'd0;
      stuff_nxt = 5'd0;
      kind_nxt  = STAMP_NONE;
      err_nxt   = 1'b0;
    end

    if (!accept) begin
      evt = '0;
    end
  end

  // New length: declared length plus the size change of the header.
  assign nl_nxt = decl + {11'd0, HDR_FIXED_LEN + stamp_len(kind_nxt)} - count_inc[15:0];

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC;
      count_r <= 17'd0;
      stuff_r <= 5'd0;
      kind_r  <= STAMP_NONE;
      err_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      stuff_r <= stuff_nxt;
      kind_r  <= kind_nxt;
      err_r   <= err_nxt;
    end
  end

  // Header and stamp byte stores.
  always_ff @(posedge clk) begin
    if (accept && hdr_we) begin
      hdr_r[3'(count_r)] <= b;
    end
    if (accept && stamp_we) begin
      stamp_r[stamp_widx] <= stamp_wdata;
    end
    if (accept && trigger) begin
      nl_r <= nl_nxt;
    end
  end

  // Rewritten header byte at the burst position.
  always_comb begin
    priority if (burst_idx < BI_LEN_HI) begin
      burst_byte = hdr_r[burst_idx[1:0]];
    end else if (burst_idx == BI_LEN_HI) begin
      burst_byte = nl_r[15:8];
    end else if (burst_idx == BI_LEN_LO) begin
      burst_byte = nl_r[7:0];
    end else if (burst_idx == BI_MARK) begin
      burst_byte = MPEG2_MARK;
    end else if (burst_idx == BI_FLAGS) begin
      burst_byte = (kind_r == STAMP_PTS) ? FLAGS_PTS :
                   (kind_r == STAMP_PTS_DTS) ? FLAGS_PTS_DTS : FLAGS_NONE;
    end else if (burst_idx == BI_HLEN) begin
      burst_byte = {3'd0, stamp_len(kind_r)};
    end else begin
      burst_byte = stamp_r[4'(burst_idx - BI_STAMP0)];
    end
  end

  assign burst_last = BI_HLEN + stamp_len(kind_r);

endmodule

// ----- rtl/mpeg1_to_mpeg2_pes_header_top.sv -----
// Top level of the MPEG-1 to MPEG-2 PES header rewriter.
// Depends on m2pes_pkg, m2pes_parse and mpeg1_to_mpeg2_pes_header_top_defines.svh.
//
//  Channel | Direction | Handshake           | Item
//  in_     | input     | in_valid / in_stall  | in_data  (in_item_t)
//  out_    | output    | out_valid/ out_stall | out_data (out_item_t)
//
// Payload bytes pass at one item per cycle while no burst, skid or out_stall holds them.
// The byte that completes the header starts a burst of 9, 14 or 19 bytes
// from the single output register; input stalls until the burst is sent.
// A one-entry skid lets an item be taken while the output register is held.
// rst_n is synchronous and clears the parser and all valid flags.
`include "mpeg1_to_mpeg2_pes_header_top_defines.svh"

module mpeg1_to_mpeg2_pes_header_top import m2pes_pkg::*; #(
  parameter int MAX_STUFFING = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic       in_accept, out_free;
  parse_evt_t evt;
  logic [7:0] burst_byte;
  logic [4:0] burst_last;

  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r, out_nxt;
  logic       sk_valid_r, sk_valid_nxt;
  out_item_t  sk_r, sk_nxt;
  logic       burst_active_r, burst_active_nxt;
  logic [4:0] burst_idx_r, burst_idx_nxt;

  assign in_stall  = sk_valid_r | burst_active_r;
  assign in_accept = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;

  m2pes_parse #(
    .MAX_STUFFING(MAX_STUFFING)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .in_item   (in_data),
    .burst_idx (burst_idx_r),
    .evt       (evt),
    .burst_byte(burst_byte),
    .burst_last(burst_last)
  );

  // Output register feed: skid first, then header burst, then new payload.
  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_nxt          = out_r;
    sk_valid_nxt     = sk_valid_r;
    sk_nxt           = sk_r;
    burst_active_nxt = burst_active_r;
    burst_idx_nxt    = burst_idx_r;

    if (out_free) begin
      out_valid_nxt = 1'b0;
      priority if (sk_valid_r) begin
        out_nxt       = sk_r;
        out_valid_nxt = 1'b1;
        sk_valid_nxt  = 1'b0;
      end else if (burst_active_r) begin
        out_nxt       = '{out_byte: burst_byte, out_end: 1'b0, packet_bad: 1'b0};
        out_valid_nxt = 1'b1;
        burst_idx_nxt = burst_idx_r + 5'd1;
        if (burst_idx_r == burst_last) begin
          burst_active_nxt = 1'b0;
        end
      end else if (evt.payload) begin
        out_nxt       = evt.item;
        out_valid_nxt = 1'b1;
      end
    end else if (evt.payload) begin
      sk_nxt       = evt.item;
      sk_valid_nxt = 1'b1;
    end

    // Header complete: start the burst from its first byte.
    if (evt.header) begin
      burst_active_nxt = 1'b1;
      burst_idx_nxt    = 5'd0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      sk_valid_r     <= 1'b0;
      burst_active_r <= 1'b0;
      burst_idx_r    <= 5'd0;
    end else begin
      out_valid_r    <= out_valid_nxt;
      sk_valid_r     <= sk_valid_nxt;
      burst_active_r <= burst_active_nxt;
      burst_idx_r    <= burst_idx_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    sk_r  <= sk_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks on the output path and burst sequencer.
  `M2PES_ASSERT_NOW(a_skid_behind_out, sk_valid_r, out_valid_r, "skid holds an item while output register is empty")
  `M2PES_ASSERT_NOW(a_burst_in_range, burst_active_r, burst_idx_r <= burst_last, "burst index ran past the header end")
  `M2PES_ASSERT_NEXT(a_burst_starts, in_accept && evt.header, burst_active_r && burst_idx_r == 5'd0, "header burst did not start at its first byte")

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for mpeg1_to_mpeg2_pes_header_top: feeds MPEG-1 PES packets
// byte by byte and compares the rewritten MPEG-2 bytes with an in-bench predictor.
// Depends on m2pes_pkg and the RTL of the top level.
module tb;
  import m2pes_pkg::*;

  localparam int STUFF_LIMIT    = 16;
  localparam int QUIET_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PKTS_PER_PHASE = 2;
  localparam int MAX_SHOWN      = 40;

  // Field codes seen in the MPEG-1 header.
  localparam logic [3:0]  STREAM_VIDEO   = 4'hE;
  localparam logic [2:0]  STREAM_AUDIO   = 3'b110;
  localparam logic [3:0]  MARK_PTS       = 4'h2;
  localparam logic [3:0]  MARK_PTS_DTS   = 4'h3;
  localparam logic [1:0]  STD_PREFIX     = 2'b01;
  localparam logic [1:0]  FLAG_PREFIX    = 2'b10;
  localparam logic [16:0] PES_PREFIX_LEN = 17'd6;

  // Ways to break an otherwise well-formed packet.
  typedef enum int {DAMAGE_NONE, DAMAGE_SYNC, DAMAGE_MPEG2} damage_t;

  // Predicts the rewritten byte stream and holds the bytes still owed by the block.
  class pes_rewrite_checker #(int LIMIT = 16);
    phase_t      ph;
    logic [7:0]  hdr [6];
    logic [7:0]  ts [10];
    logic [16:0] nbytes;
    logic [4:0]  run_cnt;
    stamp_kind_t ts_kind;
    logic        flagged;
    out_item_t   expected_bytes [$];

    function new();
      ph      = PH_SYNC;
      nbytes  = '0;
      run_cnt = '0;
      ts_kind = STAMP_NONE;
      flagged = 1'b0;
      foreach (hdr[i]) hdr[i] = '0;
      foreach (ts[i]) ts[i] = '0;
    endfunction

    function void push(logic [7:0] b, logic fin, logic bad);
      out_item_t o;
      o.out_byte   = b;
      o.out_end    = fin;
      o.packet_bad = bad;
      expected_bytes.push_back(o);
    endfunction

    // Rewritten header: start code, id, new length, flags and kept stamps.
    function void queue_header();
      logic [4:0]  nts;
      logic [7:0]  flags;
      logic [16:0] nl;
      case (ts_kind)
        STAMP_PTS: begin
          nts = LEN_PTS;
          flags = FLAGS_PTS;
        end
        STAMP_PTS_DTS: begin
          nts = LEN_PTS_DTS;
          flags = FLAGS_PTS_DTS;
        end
        default: begin
          nts = '0;
          flags = FLAGS_NONE;
        end
      endcase
      nl = {1'b0, hdr[4], hdr[5]} + 17'(HDR_FIXED_LEN) + 17'(nts) - nbytes;
      for (int i = 0; i < 4; i++) push(hdr[i], 1'b0, 1'b0);
      push(nl[15:8], 1'b0, 1'b0);
      push(nl[7:0], 1'b0, 1'b0);
      push(MPEG2_MARK, 1'b0, 1'b0);
      push(flags, 1'b0, 1'b0);
      push({3'b000, nts}, 1'b0, 1'b0);
      for (int i = 0; i < nts; i++) push(ts[i], 1'b0, 1'b0);
    endfunction

    // The byte after stuffing and STD tells whether stamps follow.
    function void take_marker(logic [7:0] b, logic fin);
      if (b[7:4] == MARK_PTS || b[7:4] == MARK_PTS_DTS) begin
        ts_kind = (b[7:4] == MARK_PTS) ? STAMP_PTS : STAMP_PTS_DTS;
        ts[0]   = b & MASK_STAMP_TOP;
        run_cnt = 5'd1;
        ph      = PH_STAMP;
      end else begin
        ts_kind = STAMP_NONE;
        run_cnt = PAYLOAD_MIN;
        ph      = PH_PAYLOAD;
        if (!fin) queue_header();
      end
    endfunction

    function void note_byte(in_item_t item);
      logic [7:0]  b;
      logic        fin;
      logic [16:0] pos;
      logic        ok;
      logic [4:0]  idx;
      logic [4:0]  total;
      logic [7:0]  m;
      logic        bad;
      b   = item.data_byte;
      fin = item.packet_end;
      pos = nbytes;
      if (nbytes != COUNT_MAX) nbytes++;
      case (ph)
        PH_SYNC: begin
          ok = 1'b1;
          if (pos == 0 || pos == 1) ok = (b == 8'h00);
          else if (pos == 2) ok = (b == START_CODE_END);
          else if (pos == 3)
            ok = (b[7:4] == STREAM_VIDEO) || (b[7:5] == STREAM_AUDIO) || (b == PRIV_STREAM_1);
          if (pos < 6) hdr[pos[2:0]] = b;
          if (!ok) ph = PH_REJECT;
          else if (pos >= 5) ph = PH_STUFF;
        end
        PH_REJECT: ;
        PH_STUFF: begin
          if (pos == 6 && b[7:6] == FLAG_PREFIX) begin
            ph = PH_REJECT;
          end else if (b[7]) begin
            if (run_cnt >= LIMIT) flagged = 1'b1;
            else run_cnt++;
          end else if (b[7:6] == STD_PREFIX) begin
            ph = PH_STD;
          end else begin
            take_marker(b, fin);
          end
        end
        PH_STD: ph = PH_MARK;
        PH_MARK: take_marker(b, fin);
        PH_STAMP: begin
          idx   = run_cnt;
          total = (ts_kind == STAMP_PTS_DTS) ? LEN_PTS_DTS : LEN_PTS;
          if (idx < 10) begin
            case (idx % 5)
              0:       m = MASK_STAMP_TOP;
              2, 4:    m = MASK_STAMP_MRK;
              default: m = MASK_STAMP_ALL;
            endcase
            ts[idx] = b & m;
          end
          idx++;
          run_cnt = idx;
          if (idx >= total) begin
            run_cnt = '0;
            ph = PH_PAYLOAD;
            if (!fin) queue_header();
          end
        end
        PH_PAYLOAD: begin
          if (run_cnt != 0) run_cnt--;
          bad = fin && (flagged || run_cnt != 0 ||
                        nbytes != {1'b0, hdr[4], hdr[5]} + PES_PREFIX_LEN);
          push(b, fin, bad);
        end
        default: ph = PH_REJECT;
      endcase
      // Every packet end returns to hunting for a start code.
      if (fin) begin
        ph      = PH_SYNC;
        nbytes  = '0;
        run_cnt = '0;
        ts_kind = STAMP_NONE;
        flagged = 1'b0;
      end
    endfunction

    function bit check_byte(out_item_t got, output string why);
      out_item_t want;
      why = "";
      if (expected_bytes.size() == 0) begin
        why = $sformatf(" unexpected byte %02h end %b bad %b",
                        got.out_byte, got.out_end, got.packet_bad);
        return 1'b0;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte)
        why = {why, $sformatf(" byte %02h want %02h", got.out_byte, want.out_byte)};
      if (got.out_end !== want.out_end)
        why = {why, $sformatf(" end %b want %b", got.out_end, want.out_end)};
      if (got.packet_bad !== want.packet_bad)
        why = {why, $sformatf(" bad %b want %b", got.packet_bad, want.packet_bad)};
      return why == "";
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int quiet = 0;

  pes_rewrite_checker #(STUFF_LIMIT) sb;

  mpeg1_to_mpeg2_pes_header_top #(.MAX_STUFFING(STUFF_LIMIT)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string why);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("%0t: output mismatch:%s", $time, why);
  endtask

  // One item: optional idle gap, then hold it until the block takes it.
  task automatic drive_byte(input logic [7:0] b, input logic fin);
    in_item_t item;
    item.data_byte  = b;
    item.packet_end = fin;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(item);
  endtask

  function automatic logic [7:0] good_sid();
    case ($urandom_range(2))
      0:       return {STREAM_VIDEO, 4'($urandom)};
      1:       return {STREAM_AUDIO, 5'($urandom)};
      default: return PRIV_STREAM_1;
    endcase
  endfunction

  function automatic logic [7:0] bad_sid();
    logic [7:0] b;
    do b = 8'($urandom);
    while (b[7:4] == STREAM_VIDEO || b[7:5] == STREAM_AUDIO || b == PRIV_STREAM_1);
    return b;
  endfunction

  // Builds one packet, optionally damaged or cut short, and sends it.
  task automatic send_pes(input logic [7:0] sid, input int n_stuff, input bit with_std,
                          input stamp_kind_t kind, input int n_pay, input int skew,
                          input int cut, input damage_t damage);
    logic [7:0]  pkt [$];
    logic [7:0]  mk;
    logic [15:0] len;
    int          n;
    pkt = {8'h00, 8'h00, START_CODE_END, sid, 8'h00, 8'h00};
    // The first stuffing byte must not look like an MPEG-2 flag byte.
    for (int i = 0; i < n_stuff; i++)
      pkt.push_back(i == 0 ? {2'b11, 6'($urandom)} : {1'b1, 7'($urandom)});
    if (with_std) begin
      pkt.push_back({STD_PREFIX, 6'($urandom)});
      pkt.push_back(8'($urandom));
    end
    case (kind)
      STAMP_PTS: begin
        pkt.push_back({MARK_PTS, 4'($urandom)});
        repeat (4) pkt.push_back(8'($urandom));
      end
      STAMP_PTS_DTS: begin
        pkt.push_back({MARK_PTS_DTS, 4'($urandom)});
        repeat (9) pkt.push_back(8'($urandom));
      end
      default: begin
        // After STD any byte outside the stamp markers will do.
        mk = with_std ? 8'($urandom) : {3'b000, 5'($urandom)};
        if (mk[7:5] == 3'b001) mk[5] = 1'b0;
        pkt.push_back(mk);
      end
    endcase
    repeat (n_pay) pkt.push_back(8'($urandom));
    len = 16'(pkt.size() - 6 + skew);
    pkt[4] = len[15:8];
    pkt[5] = len[7:0];
    if (damage == DAMAGE_SYNC) pkt[$urandom_range(2)] ^= 8'(1 << $urandom_range(7));
    if (damage == DAMAGE_MPEG2) pkt[6] = {FLAG_PREFIX, 6'($urandom)};
    n = (cut > 0 && cut < pkt.size()) ? cut : pkt.size();
    for (int i = 0; i < n; i++) drive_byte(pkt[i], i == n - 1);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 30);
    for (int i = 0; i < n; i++)
      drive_byte(8'($urandom), (i == n - 1) || ($urandom_range(15) == 0));
  endtask

  // Mostly well-formed packets with random content, the rest broken.
  task automatic send_random_pes();
    int          pick;
    int          n_stuff;
    int          n_pay;
    int          skew;
    bit          with_std;
    stamp_kind_t kind;
    pick     = $urandom_range(99);
    n_stuff  = ($urandom_range(9) == 0) ? $urandom_range(14, 20) : $urandom_range(3);
    n_pay    = ($urandom_range(4) == 0) ? $urandom_range(3) : $urandom_range(4, 10);
    with_std = $urandom_range(1);
    kind     = stamp_kind_t'($urandom_range(2));
    case ($urandom_range(9))
      0:       skew = $urandom_range(65535);
      1, 2:    skew = $urandom_range(1, 4) * ($urandom_range(1) ? 1 : -1);
      default: skew = 0;
    endcase
    if (pick < 70)
      send_pes(good_sid(), n_stuff, with_std, kind, n_pay, skew, 0, DAMAGE_NONE);
    else if (pick < 80)
      send_pes(good_sid(), n_stuff, with_std, kind, n_pay, skew, $urandom_range(1, 20),
               DAMAGE_NONE);
    else if (pick < 85)
      send_pes(bad_sid(), n_stuff, with_std, kind, n_pay, skew, 0, DAMAGE_NONE);
    else if (pick < 90)
      send_pes(good_sid(), n_stuff, with_std, kind, n_pay, skew, 0, DAMAGE_MPEG2);
    else if (pick < 95)
      send_pes(good_sid(), n_stuff, with_std, kind, n_pay, skew, 0, DAMAGE_SYNC);
    else
      send_noise();
  endtask

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Check every result the block hands over.
  always @(posedge clk) begin : check_out
    string why;
    if (rst_n && out_valid && !out_stall && !sb.check_byte(out_data, why))
      report_mismatch(why);
  end

  // Ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("mpeg1_to_mpeg2_pes_header_top regression: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int send_idle [4];
    int recv_stall [4];
    send_idle  = '{0, 48, 0, 12};
    recv_stall = '{0, 0, 48, 12};
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed packets: stream ids, stamp kinds, masks and each corner of the parser.
    send_pes(8'hE0, 0, 0, STAMP_PTS, 4, 0, 0, DAMAGE_NONE);
    send_pes(8'hC0, 2, 1, STAMP_PTS_DTS, 4, 0, 0, DAMAGE_NONE);
    send_pes(PRIV_STREAM_1, 0, 0, STAMP_NONE, 3, 0, 0, DAMAGE_NONE);
    send_pes(8'hDF, 0, 1, STAMP_NONE, 4, 0, 0, DAMAGE_NONE);
    send_pes(8'hEF, STUFF_LIMIT, 0, STAMP_PTS, 4, 0, 0, DAMAGE_NONE);
    send_pes(8'hE5, STUFF_LIMIT + 1, 1, STAMP_PTS_DTS, 4, 0, 0, DAMAGE_NONE);
    send_pes(8'hC7, 1, 0, STAMP_PTS, 4, 1, 0, DAMAGE_NONE);
    send_pes(8'hBE, 0, 0, STAMP_PTS, 1, 0, 0, DAMAGE_NONE);
    send_pes(8'hF0, 0, 0, STAMP_NONE, 1, 0, 0, DAMAGE_NONE);
    send_pes(8'hE0, 0, 0, STAMP_PTS, 1, 0, 0, DAMAGE_MPEG2);
    send_pes(8'hE0, 0, 0, STAMP_PTS, 1, 0, 0, DAMAGE_SYNC);
    // Packets that end on the byte completing the header, or earlier, then one with a short length.
    send_pes(8'hE1, 0, 0, STAMP_PTS, 0, 0, 0, DAMAGE_NONE);
    send_pes(8'hE1, 0, 1, STAMP_NONE, 0, 0, 0, DAMAGE_NONE);
    send_pes(8'hE2, 0, 0, STAMP_PTS_DTS, 10, 0, 3, DAMAGE_NONE);
    send_pes(8'hE2, 2, 0, STAMP_PTS_DTS, 10, 0, 9, DAMAGE_NONE);
    send_pes(8'hD0, 0, 0, STAMP_NONE, 8, -8, 0, DAMAGE_NONE);

    for (int p = 0; p < 4; p++) begin
      idle_pct  = send_idle[p];
      stall_pct = recv_stall[p];
      repeat (PKTS_PER_PHASE) send_random_pes();
    end

    in_valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("mpeg1_to_mpeg2_pes_header_top regression: pass");
    end else begin
      $display("mpeg1_to_mpeg2_pes_header_top regression: fail");
    end
    $finish;
  end

endmodule
